/* rtl/dmc_pkg.sv */
`default_nettype none

package dmc_pkg;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_LOAD    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_IRQ_ENABLE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_INDEX  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_CODE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEN_CODE    = 3'd4;

	localparam logic [15:0] SAMPLE_BASE  = 16'hC000;
	localparam logic [15:0] ADDR_LAST    = 16'hFFFF;
	localparam logic [15:0] ADDR_WRAP    = 16'h8000;
	localparam logic [6:0]  LEVEL_UP_MAX = 7'd125;
	localparam logic [6:0]  LEVEL_DN_MIN = 7'd2;
	localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] level_value;
		logic [7:0] sample_byte;
	} dmc_in_t;

	typedef struct packed {
		logic [6:0]  output_level;
		logic        irq_flag;
		logic [15:0] fetch_address;
		logic        fetch_taken;
		logic [11:0] bytes_left;
	} dmc_out_t;

	typedef struct packed {
		logic       irq_enable;
		logic       loop_enable;
		logic [3:0] rate_index;
		logic [7:0] addr_code;
		logic [7:0] len_code;
	} dmc_regs_t;

	typedef struct packed {
		logic [8:0]  timer_count;
		logic [6:0]  level;
		logic [7:0]  shifter;
		logic [3:0]  bit_count;
		logic        silent;
		logic [7:0]  buffer_byte;
		logic        buffer_full;
		logic [15:0] current_address;
		logic [11:0] remaining_bytes;
		logic        irq_pending;
	} dmc_state_t;

	// timer reload value: rate ROM entry minus one
	function automatic logic [8:0] rate_reload(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd0:  r = 9'd427;
			4'd1:  r = 9'd379;
			4'd2:  r = 9'd339;
			4'd3:  r = 9'd319;
			4'd4:  r = 9'd285;
			4'd5:  r = 9'd253;
			4'd6:  r = 9'd225;
			4'd7:  r = 9'd213;
			4'd8:  r = 9'd189;
			4'd9:  r = 9'd159;
			4'd10: r = 9'd141;
			4'd11: r = 9'd127;
			4'd12: r = 9'd105;
			4'd13: r = 9'd83;
			4'd14: r = 9'd71;
			default: r = 9'd53;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/dmc_if.sv */
`default_nettype none

interface dmc_in_if;
	import dmc_pkg::*;
	logic    valid;
	logic    ready;
	dmc_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dmc_out_if;
	import dmc_pkg::*;
	logic     valid;
	logic     ready;
	dmc_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dmc_cfg_if;
	import dmc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [7:0]             data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/dmc_step.sv */
`default_nettype none

module dmc_step (
	input  dmc_pkg::dmc_state_t st,
	input  dmc_pkg::dmc_regs_t  regs,
	input  dmc_pkg::dmc_in_t    item,
	output dmc_pkg::dmc_state_t nxt,
	output logic                taken
);
	import dmc_pkg::*;

	logic [15:0] reload_addr;
	logic [11:0] reload_len;
	logic [11:0] rem_dec;
	logic [3:0]  bits_dec;
	logic        can_fetch;

	assign reload_addr = SAMPLE_BASE + {2'b00, regs.addr_code, 6'b0};
	assign reload_len  = {regs.len_code, 4'b0} + 12'd1;
	assign rem_dec     = st.remaining_bytes - 12'd1;
	assign bits_dec    = (st.bit_count != 4'd0) ? st.bit_count - 4'd1 : 4'd0;
	assign can_fetch   = !st.buffer_full && (st.remaining_bytes != 12'd0);

	always_comb begin
		nxt   = st;
		taken = 1'b0;
		case (item.mode)
			MODE_TICK: begin
				if (can_fetch) begin
					taken           = 1'b1;
					nxt.buffer_byte = item.sample_byte;
					nxt.buffer_full = 1'b1;
					nxt.current_address = (st.current_address == ADDR_LAST) ? ADDR_WRAP
						: st.current_address + 16'd1;
					nxt.remaining_bytes = rem_dec;
					if (rem_dec == 12'd0) begin
						if (regs.loop_enable) begin
							nxt.current_address = reload_addr;
							nxt.remaining_bytes = reload_len;
						end else if (regs.irq_enable) begin
							nxt.irq_pending = 1'b1;
						end
					end
				end
				if (st.timer_count != 9'd0) begin
					nxt.timer_count = st.timer_count - 9'd1;
				end else begin
					nxt.timer_count = rate_reload(regs.rate_index);
					if (!st.silent) begin
						if (st.shifter[0]) begin
							if (st.level <= LEVEL_UP_MAX)
								nxt.level = st.level + 7'd2;
						end else begin
							if (st.level >= LEVEL_DN_MIN)
								nxt.level = st.level - 7'd2;
						end
					end
					nxt.shifter   = {1'b0, st.shifter[7:1]};
					nxt.bit_count = bits_dec;
					if (bits_dec == 4'd0) begin
						nxt.bit_count = BITS_PER_BYTE;
						if (nxt.buffer_full) begin
							nxt.silent      = 1'b0;
							nxt.shifter     = nxt.buffer_byte;
							nxt.buffer_full = 1'b0;
						end else begin
							nxt.silent = 1'b1;
						end
					end
				end
			end
			MODE_LOAD: begin
				nxt.level = item.level_value;
			end
			MODE_RESTART: begin
				nxt.irq_pending = 1'b0;
				if (st.remaining_bytes == 12'd0) begin
					nxt.current_address = reload_addr;
					nxt.remaining_bytes = reload_len;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/delta_modulation_sample_channel_core.sv */
`default_nettype none

// Delta-modulation sample playback channel.
// Channels: sample_in takes one item per CPU cycle (tick, direct level
// load or restart) with the memory byte at the fetch address of the
// previous result; result_out returns exactly one result per item with
// the level, IRQ flag, next fetch address, fetch flag and bytes left.
// cfg writes the five registers by index; it is always ready. The user must
// write it only while the channel is idle; the block does not enforce this.
// result_out.valid rises as the item moves from the input register into the
// result register, which waits while result_out is held. Throughput: one item
// per cycle while result_out is not held; the channel state updates as the
// item leaves the input register, so back-to-back ticks run at full rate.
// Reset: all state and registers clear, fetch address starts at C000 hex,
// no result is pending.
// Stall: while result_out is held, the result register and the waiting
// item both hold; sample_in drops ready once the input register is full.
module delta_modulation_sample_channel_core (
	input  wire        clk,
	input  wire        arst_n,
	dmc_in_if.sink     sample_in,
	dmc_out_if.source  result_out,
	dmc_cfg_if.sink    cfg
);
	import dmc_pkg::*;

	dmc_in_t    item_s1;
	logic       valid_s1;
	dmc_state_t state_q;
	dmc_regs_t  regs_q;
	dmc_out_t   out_q;
	logic       out_valid_q;

	dmc_state_t state_nxt;
	logic       taken;
	logic       advance;

	dmc_step u_step (
		.st    (state_q),
		.regs  (regs_q),
		.item  (item_s1),
		.nxt   (state_nxt),
		.taken (taken)
	);

	assign advance          = !out_valid_q || result_out.ready;
	assign sample_in.ready  = advance || !valid_s1;
	assign cfg.ready        = 1'b1;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.ready)
			item_s1 <= sample_in.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.output_level  <= state_nxt.level;
			out_q.irq_flag      <= state_nxt.irq_pending;
			out_q.fetch_address <= state_nxt.current_address;
			out_q.fetch_taken   <= taken;
			out_q.bytes_left    <= state_nxt.remaining_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				timer_count:     9'd0,
				level:           7'd0,
				shifter:         8'd0,
				bit_count:       4'd0,
				silent:          1'b0,
				buffer_byte:     8'd0,
				buffer_full:     1'b0,
				current_address: SAMPLE_BASE,
				remaining_bytes: 12'd0,
				irq_pending:     1'b0
			};
			regs_q <= '0;
		end else begin
			if (advance && valid_s1)
				state_q <= state_nxt;
			else if (cfg.valid && cfg.index == CFG_IRQ_ENABLE && !cfg.data[0])
				state_q.irq_pending <= 1'b0;
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_IRQ_ENABLE:  regs_q.irq_enable <= cfg.data[0];
					CFG_LOOP_ENABLE: regs_q.loop_enable <= cfg.data[0];
					CFG_RATE_INDEX:  regs_q.rate_index <= cfg.data[3:0];
					CFG_ADDR_CODE:   regs_q.addr_code <= cfg.data;
					CFG_LEN_CODE:    regs_q.len_code <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* sim/delta_modulation_sample_channel_checker.sv */
module delta_modulation_sample_channel_checker
	import dmc_pkg::*;
(
	input  wire clk,
	input  wire arst_n,
	dmc_in_if   sample_in,
	dmc_out_if  result_out,
	dmc_cfg_if  cfg,
	output int  mismatches,
	output int  outstanding
);

	localparam logic [8:0] STEP_PERIOD [16] = '{
		9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
		9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84, 9'd72, 9'd54
	};

	dmc_regs_t  regs;
	dmc_state_t chan;
	dmc_out_t   predicted_outputs[$];
	int         results_checked = 0;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic void load_sample_pointer();
		chan.current_address = SAMPLE_BASE + {2'b00, regs.addr_code, 6'd0};
		chan.remaining_bytes = {regs.len_code, 4'd0} + 12'd1;
	endfunction

	function automatic void compare_field(string field, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			if (mismatches < 10)
				$display("result %0d: %s expected %0d, got %0d",
					results_checked, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic step_channel(input dmc_in_t item, output dmc_out_t res);
		logic taken;
		taken = 1'b0;
		case (item.mode)
			MODE_TICK: begin
				if (!chan.buffer_full && chan.remaining_bytes != 12'd0) begin
					taken = 1'b1;
					chan.buffer_byte = item.sample_byte;
					chan.buffer_full = 1'b1;
					chan.current_address = (chan.current_address == ADDR_LAST) ?
						ADDR_WRAP : chan.current_address + 16'd1;
					chan.remaining_bytes = chan.remaining_bytes - 12'd1;
					if (chan.remaining_bytes == 12'd0) begin
						if (regs.loop_enable)
							load_sample_pointer();
						else if (regs.irq_enable)
							chan.irq_pending = 1'b1;
					end
				end
				if (chan.timer_count != 9'd0) begin
					chan.timer_count = chan.timer_count - 9'd1;
				end else begin
					chan.timer_count = STEP_PERIOD[regs.rate_index] - 9'd1;
					if (!chan.silent) begin
						if (chan.shifter[0]) begin
							if (chan.level <= LEVEL_UP_MAX)
								chan.level = chan.level + 7'd2;
						end else if (chan.level >= LEVEL_DN_MIN) begin
							chan.level = chan.level - 7'd2;
						end
					end
					chan.shifter = chan.shifter >> 1;
					if (chan.bit_count != 4'd0)
						chan.bit_count = chan.bit_count - 4'd1;
					if (chan.bit_count == 4'd0) begin
						chan.bit_count = BITS_PER_BYTE;
						if (chan.buffer_full) begin
							chan.silent = 1'b0;
							chan.shifter = chan.buffer_byte;
							chan.buffer_full = 1'b0;
						end else begin
							chan.silent = 1'b1;
						end
					end
				end
			end
			MODE_LOAD: begin
				chan.level = item.level_value;
			end
			MODE_RESTART: begin
				chan.irq_pending = 1'b0;
				if (chan.remaining_bytes == 12'd0)
					load_sample_pointer();
			end
			default: begin
			end
		endcase
		res.output_level = chan.level;
		res.irq_flag = chan.irq_pending;
		res.fetch_address = chan.current_address;
		res.fetch_taken = taken;
		res.bytes_left = chan.remaining_bytes;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		dmc_out_t got;
		dmc_out_t want;
		if (!arst_n) begin
			regs = '0;
			chan = '0;
			chan.current_address = SAMPLE_BASE;
			predicted_outputs.delete();
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_IRQ_ENABLE: begin
						regs.irq_enable = cfg.data[0];
						if (!cfg.data[0])
							chan.irq_pending = 1'b0;
					end
					CFG_LOOP_ENABLE: regs.loop_enable = cfg.data[0];
					CFG_RATE_INDEX:  regs.rate_index = cfg.data[3:0];
					CFG_ADDR_CODE:   regs.addr_code = cfg.data;
					CFG_LEN_CODE:    regs.len_code = cfg.data;
					default: begin
					end
				endcase
			end
			if (result_out.valid && result_out.ready) begin
				got = result_out.data;
				if (predicted_outputs.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d: %h arrived with nothing predicted",
							results_checked, got);
					mismatches++;
				end else begin
					want = predicted_outputs.pop_front();
					compare_field("output_level", 16'(got.output_level),
						16'(want.output_level));
					compare_field("irq_flag", 16'(got.irq_flag), 16'(want.irq_flag));
					compare_field("fetch_address", got.fetch_address, want.fetch_address);
					compare_field("fetch_taken", 16'(got.fetch_taken),
						16'(want.fetch_taken));
					compare_field("bytes_left", 16'(got.bytes_left), 16'(want.bytes_left));
				end
				results_checked++;
			end
			if (sample_in.valid && sample_in.ready) begin
				step_channel(sample_in.data, want);
				predicted_outputs.push_back(want);
			end
			outstanding = predicted_outputs.size();
		end
	end

endmodule

/* sim/delta_modulation_sample_channel_core_test.sv */
module delta_modulation_sample_channel_core_test;
	import dmc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 230;
	localparam int WRAP_TICKS = 100;
	localparam int HOLD_CYCLES = 90;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count = 0;
	int   items_sent = 0;
	int   results_seen = 0;

	dmc_in_if  sample_in();
	dmc_out_if result_out();
	dmc_cfg_if cfg();

	delta_modulation_sample_channel_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	delta_modulation_sample_channel_checker channel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_in   (sample_in),
		.result_out  (result_out),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_gap(int n);
		if ((n / 80) % 4 == 3 || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic dmc_in_t pack_item(logic [1:0] mode, logic [6:0] lvl, logic [7:0] data_byte);
		dmc_in_t item;
		item.mode = mode;
		item.level_value = lvl;
		item.sample_byte = data_byte;
		return item;
	endfunction

	function automatic dmc_in_t random_item();
		dmc_in_t item;
		int pick;
		item = pack_item(MODE_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 99);
		if (pick >= 98) begin
			item.mode = MODE_UNUSED;
		end else if (pick >= 90) begin
			item.mode = MODE_RESTART;
		end else if (pick >= 84) begin
			item.mode = MODE_LOAD;
			if ($urandom_range(0, 1) == 0)
				case ($urandom_range(0, 3))
					0: item.level_value = 7'd0;
					1: item.level_value = 7'd1;
					2: item.level_value = 7'd126;
					default: item.level_value = 7'd127;
				endcase
		end
		return item;
	endfunction

	task automatic send_item(input dmc_in_t item);
		int gap;
		gap = idle_gap(items_sent);
		if (gap > 0) begin
			sample_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_in.valid = 1'b1;
		sample_in.data = item;
		@(posedge clk);
		while (!sample_in.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_channel();
		sample_in.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic set_regs(input logic irq, input logic loop_on, input logic [3:0] rate,
		input logic [7:0] addr_code, input logic [7:0] len_code);
		drain_channel();
		write_reg(CFG_IRQ_ENABLE, {7'd0, irq});
		write_reg(CFG_LOOP_ENABLE, {7'd0, loop_on});
		write_reg(CFG_RATE_INDEX, {4'd0, rate});
		write_reg(CFG_ADDR_CODE, addr_code);
		write_reg(CFG_LEN_CODE, len_code);
	endtask

	// receiver: random stalls, plus two long hold-offs to back up the input
	initial begin : receiver
		int gap;
		result_out.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = idle_gap(results_seen);
			if (results_seen == 400 || results_seen == 1500)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				result_out.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_out.ready = 1'b1;
			@(posedge clk);
			while (!result_out.valid) @(posedge clk);
			results_seen++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int p;
		arst_n = 1'b0;
		sample_in.valid = 1'b0;
		sample_in.data = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(pack_item(MODE_TICK, 7'd0, 8'h00));
		send_item(pack_item(MODE_LOAD, 7'd127, 8'h00));
		send_item(pack_item(MODE_LOAD, 7'd0, 8'hFF));
		send_item(pack_item(MODE_UNUSED, 7'd127, 8'hFF));
		send_item(pack_item(MODE_RESTART, 7'd0, 8'h00));
		send_item(pack_item(MODE_TICK, 7'd0, 8'hFF));
		set_regs(1'b1, 1'b0, 4'd15, 8'd255, 8'd0);
		send_item(pack_item(MODE_LOAD, 7'd1, 8'h00));
		send_item(pack_item(MODE_LOAD, 7'd126, 8'h00));
		send_item(pack_item(MODE_RESTART, 7'd0, 8'h00));
		send_item(pack_item(MODE_RESTART, 7'd0, 8'h00));
		send_item(pack_item(MODE_TICK, 7'd0, 8'hA5));
		send_item(pack_item(MODE_TICK, 7'd0, 8'h5A));
		drain_channel();
		write_reg(CFG_IRQ_ENABLE, 8'd0);
		send_item(pack_item(MODE_TICK, 7'd0, 8'h3C));

		// play a sample from the top of memory
		set_regs(1'b1, 1'b0, 4'd15, 8'd255, 8'd4);
		send_item(pack_item(MODE_RESTART, 7'd0, 8'h00));
		repeat (WRAP_TICKS)
			send_item(pack_item(MODE_TICK, 7'($urandom_range(0, 127)),
				8'($urandom_range(0, 255))));

		for (p = 0; p < PHASE_COUNT; p++) begin
			set_regs(p[0], p[1],
				(p == 0) ? 4'd15 : (p == 1) ? 4'd0 : 4'($urandom_range(11, 15)),
				(p == 2) ? 8'd255 : (p == 3) ? 8'd0 : 8'($urandom_range(0, 255)),
				(p == 4) ? 8'd255 : (p == 5) ? 8'd0 : 8'($urandom_range(0, 3)));
			repeat (PHASE_ITEMS)
				send_item(random_item());
		end

		drain_channel();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
